// ===== rtl/wire_circle_arc_lines_core_macros.svh =====
// assertion helpers for the checker file
`ifndef WIRE_CIRCLE_ARC_LINES_CORE_MACROS_SVH
`define WIRE_CIRCLE_ARC_LINES_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define WCAL_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("wcal check failed");

// next-cycle implication, checked outside reset
`define WCAL_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("wcal check failed");

`endif

// ===== rtl/wcal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wcal_pkg;

  // defaults for the top level parameters
  localparam int MaxSegmentsDef = 64;
  localparam int AngleBitsDef   = 16;
  localparam int QueueDepth     = 2;
  localparam int SegW           = 7;
  localparam logic [SegW-1:0] MinSegments = 7'd3;

  // arc kinds
  localparam logic [1:0] ArcFull   = 2'd0;
  localparam logic [1:0] ArcHalf0  = 2'd1;
  localparam logic [1:0] ArcHalfPi = 2'd2;

  // polynomial coefficients, Q30
  localparam logic [31:0] SinC0 = 32'd1686629713;
  localparam logic [31:0] SinC1 = 32'd693598668;
  localparam logic [31:0] SinC2 = 32'd85569305;
  localparam logic [31:0] SinC3 = 32'd5026995;
  localparam logic [31:0] CosC0 = 32'd1324675879;
  localparam logic [31:0] CosC1 = 32'd272375560;
  localparam logic [31:0] CosC2 = 32'd22401992;
  localparam logic [31:0] CosC3 = 32'd987048;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [15:0] axis_a_x;
    logic signed [15:0] axis_a_y;
    logic signed [15:0] axis_a_z;
    logic signed [15:0] axis_b_x;
    logic signed [15:0] axis_b_y;
    logic signed [15:0] axis_b_z;
    logic signed [31:0] radius;
    logic [SegW-1:0]    segments;
    logic [1:0]         arc_kind;
  } req_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic               last_segment;
  } res_t;

  // classified request held between front and back
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [15:0] axis_a_x;
    logic signed [15:0] axis_a_y;
    logic signed [15:0] axis_a_z;
    logic signed [15:0] axis_b_x;
    logic signed [15:0] axis_b_y;
    logic signed [15:0] axis_b_z;
    logic signed [31:0] radius;
    logic [SegW-1:0]    n;
    logic               half;
    logic               start_pi;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/wire_circle_arc_lines_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | direction | handshake           | payload
// request  | in        | push / full         | req_i (wcal_pkg::req_t)
// segment  | out       | empty / pop         | res_o (wcal_pkg::res_t)
//
// one request first divides the angle range by n for the phase step, then works out
// n+1 points on the single shared 35x35 multiplier
// a request that draws nothing is taken and leaves no segment
// a two-entry queue holds classified requests while the back end works
// each segment waits in one output register; a held segment stalls the back end
// reset clears the queue, the sequencer and the output register
module wire_circle_arc_lines_core
  import wcal_pkg::*;
#(
  parameter int MAX_SEGMENTS = MaxSegmentsDef,
  parameter int ANGLE_BITS   = AngleBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t req_i,
  output logic empty,
  input  logic pop,
  output res_t res_o
);

  cmd_t cmd_in, cmd_head;
  logic keep, q_empty, q_pop, res_valid;

  wcal_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .req_i  (req_i),
    .cmd_o  (cmd_in),
    .keep_o (keep)
  );

  wcal_fifo #(.DEPTH(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && keep),
    .data_i  (cmd_in),
    .pop_i   (q_pop),
    .data_o  (cmd_head),
    .full_o  (full),
    .empty_o (q_empty)
  );

  wcal_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (q_pop),
    .res_valid_o (res_valid),
    .res_o       (res_o),
    .res_pop_i   (pop)
  );

  assign empty = !res_valid;

endmodule
`default_nettype wire

// ===== rtl/wcal_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wcal_front
  import wcal_pkg::*;
#(
  parameter int MAX_SEGMENTS = MaxSegmentsDef
) (
  input  req_t req_i,
  output cmd_t cmd_o,
  output logic keep_o
);

  localparam logic [SegW-1:0] MaxSeg = SegW'(MAX_SEGMENTS);

  // drop requests that draw nothing
  assign keep_o = (req_i.radius > 32'sd0) && (req_i.segments >= MinSegments);

  // decode arc kind and clamp the segment count
  always_comb begin
    cmd_o.center_x = req_i.center_x;
    cmd_o.center_y = req_i.center_y;
    cmd_o.center_z = req_i.center_z;
    cmd_o.axis_a_x = req_i.axis_a_x;
    cmd_o.axis_a_y = req_i.axis_a_y;
    cmd_o.axis_a_z = req_i.axis_a_z;
    cmd_o.axis_b_x = req_i.axis_b_x;
    cmd_o.axis_b_y = req_i.axis_b_y;
    cmd_o.axis_b_z = req_i.axis_b_z;
    cmd_o.radius   = req_i.radius;
    cmd_o.n        = (req_i.segments > MaxSeg) ? MaxSeg : req_i.segments;
    cmd_o.half     = (req_i.arc_kind != ArcFull);
    // the half-from-pi code and the unused code both start at pi
    cmd_o.start_pi = (req_i.arc_kind == ArcHalfPi) || (req_i.arc_kind == (ArcHalf0 | ArcHalfPi));
  end

endmodule
`default_nettype wire

// ===== rtl/wcal_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wcal_fifo
  import wcal_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wcal_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wcal_back
  import wcal_pkg::*;
#(
  parameter int ANGLE_BITS = AngleBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic res_valid_o,
  output res_t res_o,
  input  logic res_pop_i
);

  localparam int DivW = ANGLE_BITS + 1;
  localparam int CntW = $clog2(DivW + 1);

  typedef enum logic [2:0] {
    StIdle, StDiv, StPhase, StIssue, StWb, StEmit
  } state_e;

  typedef enum logic [3:0] {
    OpX2, OpS2, OpS1, OpS0, OpSm, OpC2, OpC1, OpC0, OpCm, OpAc, OpBs, OpOff
  } op_e;

  state_e                 state_q;
  op_e                    op_q;
  logic [1:0]             lane_q;
  logic [CntW-1:0]        div_cnt_q;
  logic [DivW-1:0]        num_q, quo_q;
  logic [SegW-1:0]        drem_q;
  logic [ANGLE_BITS-1:0]  step_q, phq_q;
  logic [SegW-1:0]        stepr_q, prem_q, idx_q;
  logic [29:0]            x_q;
  logic [30:0]            x2_q;
  logic                   neg_q, dneg_q;
  logic [1:0]             quad_q;
  logic [31:0]            p_q, sm_q;
  logic signed [31:0]     cs_q, sn_q;
  logic signed [47:0]     acc_q;
  logic [33:0]            mag_q;
  logic signed [69:0]     prod_q;
  logic [31:0]            prev_q [3];
  logic [31:0]            nxt_q [3];
  res_t                   out_q;
  logic                   out_valid_q;

  // divider step
  logic [SegW:0]          div_t;
  logic                   div_bit;
  logic [SegW-1:0]        div_rem;
  logic [DivW-1:0]        quo_d;
  logic                   div_last;
  assign div_t    = {drem_q, num_q[DivW-1]};
  assign div_bit  = (div_t >= {1'b0, cmd_i.n});
  assign div_rem  = div_bit ? SegW'(div_t - {1'b0, cmd_i.n}) : div_t[SegW-1:0];
  assign quo_d    = {quo_q[DivW-2:0], div_bit};
  assign div_last = (div_cnt_q == CntW'(DivW - 1));

  // phase split into quadrant and residual
  logic [ANGLE_BITS-1:0]  ph;
  logic [31:0]            turn, u;
  logic [29:0]            x_d;
  logic                   neg_d;
  assign ph    = cmd_i.start_pi ? (phq_q + {1'b1, {(ANGLE_BITS-1){1'b0}}}) : phq_q;
  assign turn  = {ph, {(32-ANGLE_BITS){1'b0}}};
  assign u     = turn + 32'h2000_0000;
  assign neg_d = !u[29];
  assign x_d   = neg_d ? (30'h2000_0000 - u[29:0]) : (u[29:0] - 30'h2000_0000);

  // per-lane operand selection
  logic signed [31:0] ctr_l;
  logic signed [15:0] ax_l, bx_l;
  always_comb begin
    case (lane_q)
      2'd0: begin
        ctr_l = cmd_i.center_x; ax_l = cmd_i.axis_a_x; bx_l = cmd_i.axis_b_x;
      end
      2'd1: begin
        ctr_l = cmd_i.center_y; ax_l = cmd_i.axis_a_y; bx_l = cmd_i.axis_b_y;
      end
      default: begin
        ctr_l = cmd_i.center_z; ax_l = cmd_i.axis_a_z; bx_l = cmd_i.axis_b_z;
      end
    endcase
  end

  // shared multiplier operands
  logic signed [34:0] ma, mb;
  always_comb begin
    case (op_q)
      OpX2: begin
        ma = $signed({5'b0, x_q}); mb = $signed({5'b0, x_q});
      end
      OpSm: begin
        ma = $signed({5'b0, x_q}); mb = $signed({3'b0, p_q});
      end
      OpAc: begin
        ma = {{19{ax_l[15]}}, ax_l}; mb = {{3{cs_q[31]}}, cs_q};
      end
      OpBs: begin
        ma = {{19{bx_l[15]}}, bx_l}; mb = {{3{sn_q[31]}}, sn_q};
      end
      OpOff: begin
        ma = $signed({1'b0, mag_q}); mb = {{3{cmd_i.radius[31]}}, cmd_i.radius};
      end
      default: begin
        ma = $signed({4'b0, x2_q}); mb = $signed({3'b0, p_q});
      end
    endcase
  end

  // writeback arithmetic
  logic [31:0]        prod_hi, cm_d;
  logic signed [31:0] s0, c0, sn_d, cs_d;
  logic signed [47:0] v_sum;
  logic signed [33:0] d_val;
  logic [69:0]        off_sum;
  logic [31:0]        off_w, coord_d;
  assign prod_hi = prod_q[61:30];
  assign cm_d    = 32'h4000_0000 - prod_hi;
  assign s0      = neg_q ? -$signed(sm_q) : $signed(sm_q);
  assign c0      = $signed(cm_d);
  always_comb begin
    case (quad_q)
      2'd0:    begin sn_d = s0;  cs_d = c0;  end
      2'd1:    begin sn_d = c0;  cs_d = -s0; end
      2'd2:    begin sn_d = -s0; cs_d = -c0; end
      default: begin sn_d = -c0; cs_d = s0;  end
    endcase
  end
  assign v_sum   = acc_q + prod_q[47:0] + 48'sd8192;
  assign d_val   = v_sum[47:14];
  assign off_sum = prod_q + 70'sd536870912;
  assign off_w   = off_sum[61:30];
  assign coord_d = ctr_l + (dneg_q ? (32'd0 - off_w) : off_w);

  // phase stepping between points
  logic [SegW:0]          prem_sum;
  logic                   prem_wrap;
  logic                   last_pt, can_load, emit_load;
  assign prem_sum  = {1'b0, prem_q} + {1'b0, stepr_q};
  assign prem_wrap = (prem_sum >= {1'b0, cmd_i.n});
  assign last_pt   = (idx_q == cmd_i.n);
  assign can_load  = !out_valid_q || res_pop_i;
  assign emit_load = (state_q == StEmit) && (idx_q != '0) && can_load;
  assign cmd_pop_o = (state_q == StEmit) && last_pt && can_load;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OpX2;
      lane_q      <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (res_pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (cmd_valid_i) begin
            num_q     <= cmd_i.half ? DivW'(1) << (ANGLE_BITS - 1) : DivW'(1) << ANGLE_BITS;
            quo_q     <= '0;
            drem_q    <= '0;
            div_cnt_q <= '0;
            state_q   <= StDiv;
          end
        end
        StDiv: begin
          num_q     <= num_q << 1;
          quo_q     <= quo_d;
          drem_q    <= div_rem;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_last) begin
            step_q  <= quo_d[ANGLE_BITS-1:0];
            stepr_q <= div_rem;
            phq_q   <= '0;
            prem_q  <= cmd_i.n >> 1;
            idx_q   <= '0;
            state_q <= StPhase;
          end
        end
        StPhase: begin
          x_q     <= x_d;
          neg_q   <= neg_d;
          quad_q  <= u[31:30];
          p_q     <= SinC3;
          op_q    <= OpX2;
          state_q <= StIssue;
        end
        StIssue: begin
          prod_q  <= ma * mb;
          state_q <= StWb;
        end
        StWb: begin
          state_q <= ((op_q == OpOff) && (lane_q == 2'd2)) ? StEmit : StIssue;
          case (op_q)
            OpX2: begin x2_q <= prod_q[60:30]; op_q <= OpS2; end
            OpS2: begin p_q <= SinC2 - prod_hi; op_q <= OpS1; end
            OpS1: begin p_q <= SinC1 - prod_hi; op_q <= OpS0; end
            OpS0: begin p_q <= SinC0 - prod_hi; op_q <= OpSm; end
            OpSm: begin sm_q <= prod_hi; p_q <= CosC3; op_q <= OpC2; end
            OpC2: begin p_q <= CosC2 - prod_hi; op_q <= OpC1; end
            OpC1: begin p_q <= CosC1 - prod_hi; op_q <= OpC0; end
            OpC0: begin p_q <= CosC0 - prod_hi; op_q <= OpCm; end
            OpCm: begin
              sn_q   <= sn_d;
              cs_q   <= cs_d;
              lane_q <= '0;
              op_q   <= OpAc;
            end
            OpAc: begin acc_q <= prod_q[47:0]; op_q <= OpBs; end
            OpBs: begin
              dneg_q <= d_val[33];
              mag_q  <= d_val[33] ? 34'(-d_val) : 34'(d_val);
              op_q   <= OpOff;
            end
            default: begin
              case (lane_q)
                2'd0:    nxt_q[0] <= coord_d;
                2'd1:    nxt_q[1] <= coord_d;
                default: nxt_q[2] <= coord_d;
              endcase
              if (lane_q != 2'd2) begin
                lane_q <= lane_q + 1'b1;
                op_q   <= OpAc;
              end
            end
          endcase
        end
        StEmit: begin
          if ((idx_q == '0) || can_load) begin
            if (idx_q != '0) begin
              out_q.start_x      <= prev_q[0];
              out_q.start_y      <= prev_q[1];
              out_q.start_z      <= prev_q[2];
              out_q.end_x        <= nxt_q[0];
              out_q.end_y        <= nxt_q[1];
              out_q.end_z        <= nxt_q[2];
              out_q.last_segment <= last_pt;
            end
            prev_q[0] <= nxt_q[0];
            prev_q[1] <= nxt_q[1];
            prev_q[2] <= nxt_q[2];
            if (last_pt) begin
              state_q <= StIdle;
            end else begin
              idx_q   <= idx_q + 1'b1;
              phq_q   <= phq_q + step_q + {{(ANGLE_BITS-1){1'b0}}, prem_wrap};
              prem_q  <= prem_wrap ? SegW'(prem_sum - {1'b0, cmd_i.n}) : prem_sum[SegW-1:0];
              state_q <= StPhase;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wcal_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "wire_circle_arc_lines_core_macros.svh"
module wcal_checker
  import wcal_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic full,
  input logic pop,
  input logic empty,
  input res_t res_o
);

  // a waiting segment stays until taken
  `WCAL_ASSERT_NEXT(a_res_held, clk_i, rst_ni, !empty && !pop, !empty)
  // and its beat does not change meanwhile
  `WCAL_ASSERT_NEXT(a_res_stable, clk_i, rst_ni, !empty && !pop, $stable(res_o))
  // nothing is shown right after reset
  `WCAL_ASSERT_NOW(a_reset_empty, clk_i, rst_ni, $rose(rst_ni), empty)
  // the request queue starts with room
  `WCAL_ASSERT_NOW(a_reset_room, clk_i, rst_ni, $rose(rst_ni), !full)

endmodule

bind wire_circle_arc_lines_core wcal_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .full   (full),
  .pop    (pop),
  .empty  (empty),
  .res_o  (res_o)
);
`default_nettype wire
